// ===== rtl/bucketed_range_table_lookup_top_defines.svh =====
// Assertion macros shared by the bucketed range table lookup RTL.
`ifndef BUCKETED_RANGE_TABLE_LOOKUP_TOP_DEFINES_SVH
`define BUCKETED_RANGE_TABLE_LOOKUP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRTL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRTL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/brtl_pkg.sv =====
// Shared constants, types and helper functions for the bucketed range table lookup.
package brtl_pkg;

    // Default sizing of the table.
    localparam int DEF_BUCKET_COUNT = 256;
    localparam int DEF_BUCKET_DEPTH = 16;

    // Fixed field widths of the request and result channels.
    localparam int BUCKET_W = 8;
    localparam int LOOKUP_W = 32;
    localparam int REGION_W = 10;

    // Request kinds.
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Index width for a store of n entries, never less than one bit.
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_fill;
        logic append;
        logic probe_issue;
        logic probe_cmp;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic cnt_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/brtl_ram.sv =====
// Generic single-port RAM with a registered read port.
module brtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = brtl_pkg::idx_width(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write when enabled; the read data is registered every cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/brtl_ctrl.sv =====
// Controller state machine that sequences appends and binary searches.
module brtl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  brtl_pkg::dp_status_t  status,
    output brtl_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILL    = 3'd1;
    localparam logic [2:0] ST_WRITE   = 3'd2;
    localparam logic [2:0] ST_SEARCH  = 3'd3;
    localparam logic [2:0] ST_COMPARE = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.load_fill = 1'b1;
                if (status.kind == brtl_pkg::KIND_APPEND) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_WRITE: begin
                cmd.append = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SEARCH: begin
                if (status.cnt_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.probe_issue = 1'b1;
                    state_next      = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                cmd.probe_cmp = 1'b1;
                state_next    = ST_SEARCH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/brtl_datapath.sv =====
// Datapath: request registers, fill count and record memories, search registers, result register.
module brtl_datapath #(
    parameter int BUCKET_COUNT = brtl_pkg::DEF_BUCKET_COUNT,
    parameter int BUCKET_DEPTH = brtl_pkg::DEF_BUCKET_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  brtl_pkg::dp_cmd_t               cmd,
    output brtl_pkg::dp_status_t            status,
    input  logic                            s_kind,
    input  logic [brtl_pkg::BUCKET_W-1:0]   s_bucket_index,
    input  logic [brtl_pkg::LOOKUP_W-1:0]   s_lookup_address,
    input  logic [brtl_pkg::LOOKUP_W-1:0]   s_record_start,
    input  logic [brtl_pkg::REGION_W-1:0]   s_record_region,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [brtl_pkg::REGION_W-1:0]   m_region_code
);

    localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int BKT_AW    = brtl_pkg::idx_width(BUCKET_COUNT);
    localparam int REC_DEPTH = BUCKET_COUNT * BUCKET_DEPTH;
    localparam int REC_AW    = brtl_pkg::idx_width(REC_DEPTH);
    localparam int REC_W     = brtl_pkg::LOOKUP_W + brtl_pkg::REGION_W;

    // Captured request.
    logic                          kind_reg;
    logic [BKT_AW-1:0]             bucket_reg;
    logic                          in_range_reg;
    logic [brtl_pkg::LOOKUP_W-1:0] addr_reg;
    logic [brtl_pkg::LOOKUP_W-1:0] start_reg;
    logic [brtl_pkg::REGION_W-1:0] region_in_reg;
    logic [REC_AW-1:0]             base_reg;
    logic [REC_AW-1:0]             base_next;
    logic                          fill_hit_reg;
    logic                          fill_hit_next;

    // Per-bucket valid bits standing in for the cleared fill counts.
    logic [BUCKET_COUNT-1:0]       fill_valid_reg;
    logic [BUCKET_COUNT-1:0]       fill_valid_next;

    // Search state.
    logic [FILL_W-1:0]             len_reg;
    logic [FILL_W-1:0]             len_next;
    logic [FILL_W-1:0]             lo_reg;
    logic [FILL_W-1:0]             lo_next;
    logic [FILL_W-1:0]             cnt_reg;
    logic [FILL_W-1:0]             cnt_next;
    logic [brtl_pkg::REGION_W-1:0] hit_region_reg;
    logic [brtl_pkg::REGION_W-1:0] hit_region_next;

    // Result register.
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          m_found_reg;
    logic                          m_found_next;
    logic [brtl_pkg::REGION_W-1:0] m_region_reg;
    logic [brtl_pkg::REGION_W-1:0] m_region_next;

    // Memory ports and helpers.
    logic                          in_range;
    logic [BKT_AW-1:0]             bucket_sel;
    logic [BKT_AW-1:0]             fill_addr;
    logic                          fill_we;
    logic [FILL_W-1:0]             fill_wdata;
    logic [FILL_W-1:0]             fill_rdata;
    logic [FILL_W-1:0]             eff_fill;
    logic                          can_append;
    logic [FILL_W-1:0]             half;
    logic [FILL_W-1:0]             probe;
    logic [REC_AW-1:0]             rec_addr;
    logic                          rec_we;
    logic [REC_W-1:0]              rec_wdata;
    logic [REC_W-1:0]              rec_rdata;
    logic [brtl_pkg::LOOKUP_W-1:0] rec_start;
    logic [brtl_pkg::REGION_W-1:0] rec_region;
    logic                          found;

    // Bucket decode at request time.
    assign in_range   = ({1'b0, s_bucket_index} < (brtl_pkg::BUCKET_W + 1)'(BUCKET_COUNT));
    assign bucket_sel = s_bucket_index[BKT_AW-1:0];
    assign base_next  = REC_AW'(bucket_sel * BUCKET_DEPTH);
    assign fill_hit_next = in_range && fill_valid_reg[bucket_sel];

    // Fill count memory: read on capture, written back by an append.
    assign eff_fill   = fill_hit_reg ? fill_rdata : '0;
    assign can_append = in_range_reg && (len_reg < FILL_W'(BUCKET_DEPTH));
    assign fill_addr  = cmd.capture ? bucket_sel : bucket_reg;
    assign fill_we    = cmd.append && can_append;
    assign fill_wdata = len_reg + FILL_W'(1);

    brtl_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKET_COUNT)
    ) u_fill_ram (
        .aclk  (aclk),
        .we    (fill_we),
        .addr  (fill_addr),
        .wdata (fill_wdata),
        .rdata (fill_rdata)
    );

    // Record memory: appended at the fill position, probed by the search.
    assign half       = cnt_reg >> 1;
    assign probe      = lo_reg + half;
    assign rec_addr   = cmd.append ? (base_reg + REC_AW'(len_reg))
                                   : (base_reg + REC_AW'(probe));
    assign rec_we     = cmd.append && can_append;
    assign rec_wdata  = {start_reg, region_in_reg};
    assign rec_start  = rec_rdata[REC_W-1 -: brtl_pkg::LOOKUP_W];
    assign rec_region = rec_rdata[brtl_pkg::REGION_W-1:0];

    brtl_ram #(
        .WIDTH (REC_W),
        .DEPTH (REC_DEPTH)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .addr  (rec_addr),
        .wdata (rec_wdata),
        .rdata (rec_rdata)
    );

    // A record is found only when some start lies above the address and the first such start is not the first record.
    assign found = (lo_reg != '0) && (lo_reg != len_reg);

    // Valid bit update on a successful append.
    always_comb begin
        fill_valid_next = fill_valid_reg;
        if (fill_we) begin
            fill_valid_next[bucket_reg] = 1'b1;
        end
    end

    // Binary search step: move past the probe when its start is not above the address.
    always_comb begin
        len_next        = len_reg;
        lo_next         = lo_reg;
        cnt_next        = cnt_reg;
        hit_region_next = hit_region_reg;
        if (cmd.load_fill) begin
            len_next = eff_fill;
            cnt_next = eff_fill;
            lo_next  = '0;
        end else if (cmd.probe_cmp) begin
            if (rec_start <= addr_reg) begin
                lo_next         = probe + FILL_W'(1);
                cnt_next        = cnt_reg - half - FILL_W'(1);
                hit_region_next = rec_region;
            end else begin
                cnt_next = half;
            end
        end
    end

    // Result register: loaded when the slot is free, cleared when taken.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_found_next  = m_found_reg;
        m_region_next = m_region_reg;
        if (cmd.out_load) begin
            m_valid_next  = 1'b1;
            m_found_next  = found;
            m_region_next = found ? hit_region_reg : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            fill_valid_reg <= fill_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg      <= s_kind;
            bucket_reg    <= bucket_sel;
            in_range_reg  <= in_range;
            addr_reg      <= s_lookup_address;
            start_reg     <= s_record_start;
            region_in_reg <= s_record_region;
            base_reg      <= base_next;
            fill_hit_reg  <= fill_hit_next;
        end
        len_reg        <= len_next;
        lo_reg         <= lo_next;
        cnt_reg        <= cnt_next;
        hit_region_reg <= hit_region_next;
        m_found_reg    <= m_found_next;
        m_region_reg   <= m_region_next;
    end

    assign status.kind     = kind_reg;
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_region_code = m_region_reg;

endmodule

// ===== rtl/bucketed_range_table_lookup_top.sv =====
// Bucketed range table lookup: top level joining the controller and the datapath.
//
// Requests arrive on the s_ channel (valid/ready). An append request (s_kind = 0) adds a
// record to the end of bucket s_bucket_index and gives no result. Appends
// to a full bucket or to a bucket beyond the table are dropped. A lookup request (s_kind = 1)
// binary-searches its bucket and gives one result on the m_ channel: m_found and the region
// code of the record that covers s_lookup_address (zero when not found).
// A lookup reads its bucket's fill count, runs S search steps and loads the result register,
// where S is the number of search steps (at most log2(fill) + 1). Each step is one registered
// read of the record memory followed by a compare, through the single memory port. Requests
// are handled one at a time: a lookup or an append must finish before the next can be accepted.
// The result sits in an output register, so a new request is accepted while a result still
// waits. When the receiver stalls, a later lookup holds in its final step until the result
// register is taken. Reset clears the per-bucket fill counts at once through valid bits;
// the record memory is not cleared and needs no clearing pass.
module bucketed_range_table_lookup_top #(
    parameter int BUCKET_COUNT = brtl_pkg::DEF_BUCKET_COUNT,
    parameter int BUCKET_DEPTH = brtl_pkg::DEF_BUCKET_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [brtl_pkg::BUCKET_W-1:0]   s_bucket_index,
    input  logic [brtl_pkg::LOOKUP_W-1:0]   s_lookup_address,
    input  logic [brtl_pkg::LOOKUP_W-1:0]   s_record_start,
    input  logic [brtl_pkg::REGION_W-1:0]   s_record_region,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [brtl_pkg::REGION_W-1:0]   m_region_code
);

`include "bucketed_range_table_lookup_top_defines.svh"

    brtl_pkg::dp_cmd_t    dp_cmd;
    brtl_pkg::dp_status_t dp_status;

    // Sequencing of each request.
    brtl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    // Storage, search registers and the result register.
    brtl_datapath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (dp_cmd),
        .status           (dp_status),
        .s_kind           (s_kind),
        .s_bucket_index   (s_bucket_index),
        .s_lookup_address (s_lookup_address),
        .s_record_start   (s_record_start),
        .s_record_region  (s_record_region),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_region_code    (m_region_code)
    );

    // A not-found result always carries a zero region code.
    `BRTL_ASSERT_SAME(a_notfound_zero, aclk, aresetn, m_valid && !m_found, m_region_code == '0)
    // The block works on one request at a time.
    `BRTL_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A result is never loaded over one that has not been taken.
    `BRTL_ASSERT_SAME(a_out_load_free, aclk, aresetn, dp_cmd.out_load, !m_valid || m_ready)

endmodule
